// ----- design/mtw_pkg.sv -----
// Shared constants, types and word functions for the MT19937 word generator.
package mtw_pkg;

    localparam int unsigned TABLE_WORDS = 624;
    localparam int unsigned SHIFT_DIST  = 397;
    localparam int unsigned SPLIT_POINT = 227;
    localparam int unsigned POS_W       = $clog2(TABLE_WORDS);

    typedef logic [31:0]      word_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam word_t INIT_MULT  = 32'd1812433253;
    localparam word_t MATRIX_A   = 32'h9908b0df;
    localparam word_t UPPER_MASK = 32'h80000000;
    localparam word_t LOWER_MASK = 32'h7fffffff;
    localparam word_t TEMPER_B   = 32'd2636928640;
    localparam word_t TEMPER_C   = 32'd4022730752;

    localparam pos_t LAST_POS  = POS_W'(TABLE_WORDS - 1);
    localparam pos_t FAR_FWD   = POS_W'(SHIFT_DIST);
    localparam pos_t FAR_BACK  = POS_W'(SPLIT_POINT);

    localparam logic REG_SEED_IDX = 1'b0;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_NEXT,
        RD_FAR
    } rd_sel_t;

    typedef struct packed {
        logic    seed_load;
        logic    seed_write;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_cur;
        logic    cap_next;
        logic    mix_write;
        logic    out_load;
    } mtw_cmd_t;

    typedef struct packed {
        logic seeded;
        logic fill_last;
        logic out_free;
    } mtw_stat_t;

    function automatic word_t mix_words(input word_t hi_src, input word_t lo_src,
                                        input word_t far_src);
        word_t y;
        word_t r;
        y = (hi_src & UPPER_MASK) | (lo_src & LOWER_MASK);
        r = far_src ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ MATRIX_A;
        end
        return r;
    endfunction

    function automatic word_t temper(input word_t y);
        word_t t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    function automatic word_t seed_step(input word_t prev, input pos_t idx);
        word_t x;
        word_t p;
        x = prev ^ (prev >> 30);
        p = word_t'(INIT_MULT * x);
        return p + {{(32 - POS_W){1'b0}}, idx};
    endfunction

endpackage

// ----- design/mtw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mtw_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/mtw_ctrl.sv -----
// Controller state machine: seeding sweep and per-word read, mix and delivery sequence.
module mtw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_reseed,
    output logic              in_ready,
    input  mtw_pkg::mtw_stat_t stat,
    output mtw_pkg::mtw_cmd_t  cmd
);

    import mtw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_CUR,
        ST_NEXT,
        ST_FAR,
        ST_MIX,
        ST_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CUR;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_reseed || !stat.seeded)
                    begin
                        cmd.seed_load = 1'b1;
                        state_next    = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_CUR;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.seed_write = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_CUR;
                end
            end
            ST_CUR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.cap_cur = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_NEXT;
                state_next  = ST_FAR;
            end
            ST_FAR:
            begin
                cmd.cap_next = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_FAR;
                state_next   = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix_write = 1'b1;
                state_next    = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/mtw_dpath.sv -----
// Datapath: state table, read position, seeding recurrence, lazy twist and tempering.
module mtw_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  mtw_pkg::mtw_cmd_t  cmd,
    output mtw_pkg::mtw_stat_t stat,
    input  mtw_pkg::word_t     seed_value,
    input  logic               out_ready,
    output logic               out_valid,
    output mtw_pkg::word_t     out_word
);

    import mtw_pkg::*;

    pos_t  pos_reg;
    pos_t  pos_next;
    pos_t  fill_cnt_reg;
    pos_t  fill_cnt_next;
    logic  seeded_reg;
    logic  seeded_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    word_t prev_reg;
    word_t prev_next;
    word_t cur_reg;
    word_t nxt_reg;
    word_t mix_reg;
    word_t out_word_reg;

    pos_t  fill_inc;
    pos_t  pos_inc;
    pos_t  far_addr;
    pos_t  rd_addr;
    pos_t  wr_addr;
    word_t wr_data;
    word_t rd_data;
    word_t mix_value;
    logic  wr_en;

    assign fill_inc  = fill_cnt_reg + 1'b1;
    assign pos_inc   = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign far_addr  = (pos_reg < FAR_BACK) ? pos_reg + FAR_FWD : pos_reg - FAR_BACK;
    assign mix_value = mix_words(cur_reg, nxt_reg, rd_data);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_CUR:  rd_addr = pos_reg;
            RD_NEXT: rd_addr = pos_inc;
            RD_FAR:  rd_addr = far_addr;
            default: rd_addr = pos_reg;
        endcase
    end

    assign wr_en   = cmd.seed_write | cmd.mix_write;
    assign wr_addr = cmd.seed_write ? fill_cnt_reg : pos_reg;
    assign wr_data = cmd.seed_write ? prev_reg : mix_value;

    mtw_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.seeded    = seeded_reg;
    assign stat.fill_last = (fill_cnt_reg == LAST_POS);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        pos_next       = pos_reg;
        fill_cnt_next  = fill_cnt_reg;
        seeded_next    = seeded_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg;
        if (cmd.seed_load)
        begin
            pos_next      = '0;
            fill_cnt_next = '0;
            prev_next     = seed_value;
        end
        if (cmd.seed_write)
        begin
            prev_next = seed_step(prev_reg, fill_inc);
            if (stat.fill_last)
            begin
                seeded_next = 1'b1;
            end
            else
            begin
                fill_cnt_next = fill_inc;
            end
        end
        if (cmd.mix_write)
        begin
            pos_next = pos_inc;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_cnt_reg  <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            fill_cnt_reg  <= fill_cnt_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        if (cmd.cap_cur)
        begin
            cur_reg <= rd_data;
        end
        if (cmd.cap_next)
        begin
            nxt_reg <= rd_data;
        end
        if (cmd.mix_write)
        begin
            mix_reg <= mix_value;
        end
        if (cmd.out_load)
        begin
            out_word_reg <= temper(mix_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("read position beyond table");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mix_write && !cmd.seed_load |=> pos_reg == $past(pos_inc))
        else $error("read position did not advance after mix");

    a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seed_write && stat.fill_last |=> seeded_reg && pos_reg == '0)
        else $error("seeding sweep finished without marking table seeded");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.seed_write && cmd.mix_write))
        else $error("seed and mix writes in the same cycle");

endmodule

// ----- design/mt19937_word_generator.sv -----
// Top level of the MT19937 word generator: stream ports, APB seed register, controller, datapath.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata[0] reseed
//  m_axis    out        m_axis_tvalid/tready        tdata[31:0] random_word
//  apb       in         psel/penable/pwrite/pready  seed_value at byte address 0
//
//  A draw runs from acceptance to the word entering the output register through
//  three table reads, one mix and write-back, one tempering load, set by the single
//  read port of the table RAM. A new request is accepted only after the last word is loaded.
//  A reseed, and the first word after reset, add a seeding sweep over all 624 table
//  words, one table word per cycle through the seeding multiplier.
//  The output register holds a finished word while the next request is accepted;
//  a full output register holds the sequence before tempering.
module mt19937_word_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] random_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import mtw_pkg::*;

    mtw_cmd_t  cmd;
    mtw_stat_t stat;
    word_t     seed_value_reg;
    word_t     seed_value_next;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        seed_value_next = seed_value_reg;
        if (cfg_write && (paddr[2] == REG_SEED_IDX))
        begin
            seed_value_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_value_reg <= '0;
        end
        else
        begin
            seed_value_reg <= seed_value_next;
        end
    end

    assign prdata = (paddr[2] == REG_SEED_IDX) ? seed_value_reg : '0;

    mtw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_reseed (s_axis_tdata[0]),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtw_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .seed_value (seed_value_reg),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_word   (m_axis_tdata)
    );

endmodule
